// File: design/le3d_pkg.sv
// Shared constants and types of the six-neighbour label erosion block.
package le3d_pkg;

    // Payload widths.
    localparam int LABEL_W = 16;

    // Configuration register widths and port widths.
    localparam int X_SIZE_W   = 13;
    localparam int Y_SIZE_W   = 7;
    localparam int Z_SIZE_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = 2'd2;

    // Register reset values and the plane count limit.
    localparam logic [X_SIZE_W-1:0] X_SIZE_RESET = 13'd64;
    localparam logic [Y_SIZE_W-1:0] Y_SIZE_RESET = 7'd64;
    localparam logic [Z_SIZE_W-1:0] Z_SIZE_RESET = 7'd64;
    localparam int                  X_LIMIT      = 4096;

    // Default values of the top level parameters.
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_LABEL_BITS = 16;

    // Which face neighbours of a voxel lie inside the volume, and whether
    // the voxel is the final one of the volume.
    typedef struct packed {
        logic xm;
        logic xp;
        logic ym;
        logic yp;
        logic zm;
        logic zp;
        logic last;
    } le3d_nbr_t;

endpackage

// File: design/le3d_in_if.sv
// Voxel input channel: valid/ready handshake with label and flush payload.
interface le3d_in_if import le3d_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] voxel_label;
    logic               flush;

    modport source (output valid, output voxel_label, output flush, input ready);
    modport sink   (input valid, input voxel_label, input flush, output ready);

endinterface

// File: design/le3d_out_if.sv
// Result output channel: valid/ready handshake with eroded label payload.
interface le3d_out_if import le3d_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] out_label;
    logic               last_voxel;

    modport source (output valid, output out_label, output last_voxel, input ready);
    modport sink   (input valid, input out_label, input last_voxel, output ready);

endinterface

// File: design/le3d_ram.sv
// Label delay store: one write port and two registered read ports.
module le3d_ram import le3d_pkg::*; #(
    parameter int DEPTH = 2 * DEF_MAX_ROWS * DEF_MAX_COLS + 1,
    parameter int DW    = LABEL_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [DW-1:0]            rd_data_a,
    output logic [DW-1:0]            rd_data_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read in the same cycle as a write to the same entry returns the old data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// File: design/le3d_ctrl.sv
// Configuration registers, volume position counters and stencil addressing.
module le3d_ctrl import le3d_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int DEPTH   = 2 * MAX_ROWS * MAX_COLS + 1,
    localparam int AW      = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  flush,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic                  emit,
    output le3d_nbr_t             nbr,
    output logic [AW-1:0]         addr_c,
    output logic [AW-1:0]         addr_zp,
    output logic [AW-1:0]         addr_yp,
    output logic [AW-1:0]         addr_ym,
    output logic [AW-1:0]         addr_xp,
    output logic [AW-1:0]         addr_xm
);

    localparam int AW1 = AW + 1;
    localparam int YW  = $clog2(MAX_ROWS + 1);
    localparam int ZW  = $clog2(MAX_COLS + 1);
    localparam int PW  = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int XW  = X_SIZE_W;

    logic [X_SIZE_W-1:0] x_size_reg, x_size_next;
    logic [Y_SIZE_W-1:0] y_size_reg, y_size_next;
    logic [Z_SIZE_W-1:0] z_size_reg, z_size_next;

    logic [XW-1:0] in_x_reg, in_x_next;
    logic [YW-1:0] in_y_reg, in_y_next;
    logic [ZW-1:0] in_z_reg, in_z_next;
    logic [XW-1:0] out_x_reg, out_x_next;
    logic [YW-1:0] out_y_reg, out_y_next;
    logic [ZW-1:0] out_z_reg, out_z_next;
    logic          all_in_reg, all_in_next;
    logic [PW-1:0] diff_reg, diff_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [AW-1:0] rd_base_reg, rd_base_next;

    logic [XW-1:0] xs;
    logic [YW-1:0] ys;
    logic [ZW-1:0] zs;
    logic [PW-1:0] plane;
    logic          in_last;
    logic          out_last;
    logic          flush_emit;
    logic          done;

    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [PW-1:0] off);
        logic [AW1-1:0] s;
        s = AW1'(base) + AW1'(off);
        if (s >= AW1'(DEPTH))
        begin
            s = s - AW1'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_sub(logic [AW-1:0] base, logic [PW-1:0] off);
        logic [AW1-1:0] s;
        if (AW1'(base) >= AW1'(off))
        begin
            s = AW1'(base) - AW1'(off);
        end
        else
        begin
            s = AW1'(base) + AW1'(DEPTH) - AW1'(off);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + AW'(1);
        end
        return r;
    endfunction

    // Sizes held to their legal ranges; zero counts as one.
    always_comb
    begin
        if (x_size_reg == '0)
        begin
            xs = XW'(1);
        end
        else if (x_size_reg > XW'(X_LIMIT))
        begin
            xs = XW'(X_LIMIT);
        end
        else
        begin
            xs = x_size_reg;
        end

        if (y_size_reg == '0)
        begin
            ys = YW'(1);
        end
        else if (32'(y_size_reg) > MAX_ROWS)
        begin
            ys = YW'(MAX_ROWS);
        end
        else
        begin
            ys = YW'(y_size_reg);
        end

        if (z_size_reg == '0)
        begin
            zs = ZW'(1);
        end
        else if (32'(z_size_reg) > MAX_COLS)
        begin
            zs = ZW'(MAX_COLS);
        end
        else
        begin
            zs = ZW'(z_size_reg);
        end
    end

    assign plane = PW'(ys) * PW'(zs);

    assign in_last  = (in_x_reg == xs - XW'(1)) && (in_y_reg == ys - YW'(1))
                   && (in_z_reg == zs - ZW'(1));
    assign out_last = (out_x_reg == xs - XW'(1)) && (out_y_reg == ys - YW'(1))
                   && (out_z_reg == zs - ZW'(1));

    // A voxel is stored only while the volume still expects voxels. The
    // result one plane behind becomes ready once its far neighbour is in.
    assign wr_en      = accept && !flush && !all_in_reg;
    assign flush_emit = accept && flush && all_in_reg;
    assign emit       = (wr_en && (diff_reg >= plane)) || flush_emit;
    assign done       = emit && out_last;
    assign wr_addr    = wr_addr_reg;

    assign nbr.xm   = (out_x_reg != '0);
    assign nbr.xp   = (out_x_reg != xs - XW'(1));
    assign nbr.ym   = (out_y_reg != '0);
    assign nbr.yp   = (out_y_reg != ys - YW'(1));
    assign nbr.zm   = (out_z_reg != '0);
    assign nbr.zp   = (out_z_reg != zs - ZW'(1));
    assign nbr.last = out_last;

    assign addr_c  = rd_base_reg;
    assign addr_zp = ring_add(rd_base_reg, PW'(1));
    assign addr_yp = ring_add(rd_base_reg, PW'(zs));
    assign addr_ym = ring_sub(rd_base_reg, PW'(zs));
    assign addr_xp = ring_add(rd_base_reg, plane);
    assign addr_xm = ring_sub(rd_base_reg, plane);

    always_comb
    begin
        x_size_next  = x_size_reg;
        y_size_next  = y_size_reg;
        z_size_next  = z_size_reg;
        in_x_next    = in_x_reg;
        in_y_next    = in_y_reg;
        in_z_next    = in_z_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_z_next   = out_z_reg;
        all_in_next  = all_in_reg;
        diff_next    = diff_reg;
        wr_addr_next = wr_addr_reg;
        rd_base_next = rd_base_reg;

        if (cfg_we || done)
        begin
            // Any register write, or the final result, starts a new volume.
            in_x_next    = '0;
            in_y_next    = '0;
            in_z_next    = '0;
            out_x_next   = '0;
            out_y_next   = '0;
            out_z_next   = '0;
            all_in_next  = 1'b0;
            diff_next    = '0;
            wr_addr_next = '0;
            rd_base_next = '0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_X_SIZE: x_size_next = cfg_data[X_SIZE_W-1:0];
                    CFG_Y_SIZE: y_size_next = cfg_data[Y_SIZE_W-1:0];
                    CFG_Z_SIZE: z_size_next = cfg_data[Z_SIZE_W-1:0];
                    default:    x_size_next = x_size_reg;
                endcase
            end
        end
        else
        begin
            if (wr_en)
            begin
                wr_addr_next = ring_inc(wr_addr_reg);
                if (in_last)
                begin
                    all_in_next = 1'b1;
                end
                if (in_z_reg == zs - ZW'(1))
                begin
                    in_z_next = '0;
                    if (in_y_reg == ys - YW'(1))
                    begin
                        in_y_next = '0;
                        in_x_next = in_x_reg + XW'(1);
                    end
                    else
                    begin
                        in_y_next = in_y_reg + YW'(1);
                    end
                end
                else
                begin
                    in_z_next = in_z_reg + ZW'(1);
                end
            end

            if (emit)
            begin
                rd_base_next = ring_inc(rd_base_reg);
                if (out_z_reg == zs - ZW'(1))
                begin
                    out_z_next = '0;
                    if (out_y_reg == ys - YW'(1))
                    begin
                        out_y_next = '0;
                        out_x_next = out_x_reg + XW'(1);
                    end
                    else
                    begin
                        out_y_next = out_y_reg + YW'(1);
                    end
                end
                else
                begin
                    out_z_next = out_z_reg + ZW'(1);
                end
            end

            if (flush_emit)
            begin
                diff_next = diff_reg - PW'(1);
            end
            else if (wr_en && !emit)
            begin
                diff_next = diff_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_size_reg  <= X_SIZE_RESET;
            y_size_reg  <= Y_SIZE_RESET;
            z_size_reg  <= Z_SIZE_RESET;
            in_x_reg    <= '0;
            in_y_reg    <= '0;
            in_z_reg    <= '0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            out_z_reg   <= '0;
            all_in_reg  <= 1'b0;
            diff_reg    <= '0;
            wr_addr_reg <= '0;
            rd_base_reg <= '0;
        end
        else
        begin
            x_size_reg  <= x_size_next;
            y_size_reg  <= y_size_next;
            z_size_reg  <= z_size_next;
            in_x_reg    <= in_x_next;
            in_y_reg    <= in_y_next;
            in_z_reg    <= in_z_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            out_z_reg   <= out_z_next;
            all_in_reg  <= all_in_next;
            diff_reg    <= diff_next;
            wr_addr_reg <= wr_addr_next;
            rd_base_reg <= rd_base_next;
        end
    end

endmodule

// File: design/label_erosion_3d_six_neighbour_top.sv
// Top level of the streaming six-neighbour label erosion of a 3D volume.
// Throughput: one word per cycle on each side unless the output stalls; the store has one write
// and two reads per copy. A released result passes stage 1, stage 2 and the output register.
// A voxel's result is released by the voxel one plane later; flush words release the last plane.
// Reset clears the pipeline and volume positions and loads all three sizes with 64.
// The delay store is not cleared: only entries written in the current volume are used.
module label_erosion_3d_six_neighbour_top import le3d_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int LABEL_BITS = DEF_LABEL_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    le3d_in_if.sink               voxel,
    le3d_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The store keeps two planes plus one voxel, addressed as a ring.
    localparam int DEPTH = 2 * MAX_ROWS * MAX_COLS + 1;
    localparam int AW    = $clog2(DEPTH);
    // Labels are kept at the narrower of the parameter and the field width.
    localparam int SW    = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          emit;
    le3d_nbr_t     nbr;
    logic [AW-1:0] addr_c, addr_zp, addr_yp, addr_ym, addr_xp, addr_xm;

    // Stage 1 holds the stencil addresses of a released voxel.
    logic          s1_valid_reg;
    le3d_nbr_t     s1_nbr_reg;
    logic [AW-1:0] s1_c_reg, s1_zp_reg, s1_yp_reg, s1_ym_reg, s1_xp_reg, s1_xm_reg;

    // Stage 2 holds the neighbour labels, read from the store copies.
    logic          s2_valid_reg;
    le3d_nbr_t     s2_nbr_reg;
    logic [SW-1:0] lbl_c, lbl_zp, lbl_yp, lbl_ym, lbl_xp, lbl_xm;

    // The previous voxel's label serves as the lower z neighbour, since
    // results leave in raster order and consecutive results are z neighbours.
    logic [SW-1:0] left_reg;

    logic               out_valid_reg;
    logic [LABEL_W-1:0] out_label_reg;
    logic               out_last_reg;

    logic          out_free;
    logic          s2_en;
    logic          s1_en;
    logic          eroded;
    logic [SW-1:0] label_next;

    // Each stage moves when the one after it is empty or moving, so words
    // are still taken while the output word waits if stage 1 or 2 is empty.
    assign out_free    = !out_valid_reg || result.ready;
    assign s2_en       = !s2_valid_reg || out_free;
    assign s1_en       = !s1_valid_reg || s2_en;
    assign voxel.ready = s1_en;
    assign accept      = voxel.valid && s1_en;

    le3d_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .flush     (voxel.flush),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .emit      (emit),
        .nbr       (nbr),
        .addr_c    (addr_c),
        .addr_zp   (addr_zp),
        .addr_yp   (addr_yp),
        .addr_ym   (addr_ym),
        .addr_xp   (addr_xp),
        .addr_xm   (addr_xm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && emit)
        begin
            s1_nbr_reg <= nbr;
            s1_c_reg   <= addr_c;
            s1_zp_reg  <= addr_zp;
            s1_yp_reg  <= addr_yp;
            s1_ym_reg  <= addr_ym;
            s1_xp_reg  <= addr_xp;
            s1_xm_reg  <= addr_xm;
        end
    end

    // Three copies of the store, all written alike, give six reads a cycle.
    le3d_ram #(
        .DEPTH (DEPTH),
        .DW    (SW)
    ) u_ram_z (
        .clk       (clk),
        .we        (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (voxel.voxel_label[SW-1:0]),
        .re        (s2_en && s1_valid_reg),
        .rd_addr_a (s1_c_reg),
        .rd_addr_b (s1_zp_reg),
        .rd_data_a (lbl_c),
        .rd_data_b (lbl_zp)
    );

    le3d_ram #(
        .DEPTH (DEPTH),
        .DW    (SW)
    ) u_ram_y (
        .clk       (clk),
        .we        (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (voxel.voxel_label[SW-1:0]),
        .re        (s2_en && s1_valid_reg),
        .rd_addr_a (s1_yp_reg),
        .rd_addr_b (s1_ym_reg),
        .rd_data_a (lbl_yp),
        .rd_data_b (lbl_ym)
    );

    le3d_ram #(
        .DEPTH (DEPTH),
        .DW    (SW)
    ) u_ram_x (
        .clk       (clk),
        .we        (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (voxel.voxel_label[SW-1:0]),
        .re        (s2_en && s1_valid_reg),
        .rd_addr_a (s1_xp_reg),
        .rd_addr_b (s1_xm_reg),
        .rd_data_a (lbl_xp),
        .rd_data_b (lbl_xm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_nbr_reg <= s1_nbr_reg;
        end
    end

    // A voxel erodes when it is background or any neighbour inside the
    // volume is background; neighbours outside the volume do not count.
    always_comb
    begin
        eroded = (lbl_c == '0)
              || (s2_nbr_reg.zm && (left_reg == '0))
              || (s2_nbr_reg.zp && (lbl_zp == '0))
              || (s2_nbr_reg.ym && (lbl_ym == '0))
              || (s2_nbr_reg.yp && (lbl_yp == '0))
              || (s2_nbr_reg.xm && (lbl_xm == '0))
              || (s2_nbr_reg.xp && (lbl_xp == '0));
        label_next = eroded ? '0 : lbl_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            out_label_reg <= LABEL_W'(label_next);
            out_last_reg  <= s2_nbr_reg.last;
            left_reg      <= lbl_c;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_label  = out_label_reg;
    assign result.last_voxel = out_last_reg;

endmodule

// File: tb/le3d_erosion_checker.sv
// Checker for the label erosion block: predicts every result word and compares it.
module le3d_erosion_checker import le3d_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int LABEL_BITS = DEF_LABEL_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    le3d_in_if                    voxel,
    le3d_out_if                   result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DELAY_DEPTH = 2 * MAX_ROWS * MAX_COLS + 1;
    localparam logic [LABEL_W-1:0] LABEL_MASK = LABEL_W'((64'd1 << LABEL_BITS) - 64'd1);

    typedef struct packed {
        logic [LABEL_W-1:0] out_label;
        logic               last_voxel;
    } result_word_t;

    logic [LABEL_W-1:0]  delay_line [DELAY_DEPTH];
    int unsigned         voxels_in;
    int unsigned         words_out;
    logic [X_SIZE_W-1:0] x_size;
    logic [Y_SIZE_W-1:0] y_size;
    logic [Z_SIZE_W-1:0] z_size;
    result_word_t        eroded_due [$];

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [LABEL_W-1:0] delay_at(input int unsigned pos);
        return delay_line[pos % DELAY_DEPTH];
    endfunction

    // A voxel survives only if it and every face neighbour inside the volume are nonzero.
    function automatic logic [LABEL_W-1:0] eroded_label(input int unsigned q,
            input int unsigned xs, input int unsigned ys, input int unsigned zs);
        int unsigned        plane;
        int unsigned        zi;
        int unsigned        yi;
        int unsigned        xi;
        logic [LABEL_W-1:0] centre;
        plane  = ys * zs;
        centre = delay_at(q);
        zi     = q % zs;
        yi     = (q / zs) % ys;
        xi     = q / plane;
        if (centre == '0)
            return '0;
        if (xi > 0 && delay_at(q - plane) == '0)
            return '0;
        if (xi + 1 < xs && delay_at(q + plane) == '0)
            return '0;
        if (yi > 0 && delay_at(q - zs) == '0)
            return '0;
        if (yi + 1 < ys && delay_at(q + zs) == '0)
            return '0;
        if (zi > 0 && delay_at(q - 1) == '0)
            return '0;
        if (zi + 1 < zs && delay_at(q + 1) == '0)
            return '0;
        return centre;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_count < 10)
        begin
            $display("%0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic absorb_word(input logic [LABEL_W-1:0] label, input logic flush);
        int unsigned  xs;
        int unsigned  ys;
        int unsigned  zs;
        int unsigned  plane;
        int unsigned  total;
        bit           release_one;
        result_word_t word;
        xs          = fit_size(x_size, X_LIMIT);
        ys          = fit_size(y_size, MAX_ROWS);
        zs          = fit_size(z_size, MAX_COLS);
        plane       = ys * zs;
        total       = xs * plane;
        release_one = 1'b0;
        if (!flush)
        begin
            // Voxels beyond the end of the volume are dropped.
            if (voxels_in >= total)
                return;
            delay_line[voxels_in % DELAY_DEPTH] = label & LABEL_MASK;
            voxels_in++;
            release_one = (voxels_in > words_out + plane);
        end
        else
        begin
            release_one = (voxels_in >= total && words_out < total);
        end
        if (!release_one)
            return;
        word.out_label  = eroded_label(words_out, xs, ys, zs);
        word.last_voxel = (words_out + 1 == total);
        eroded_due.push_back(word);
        words_out++;
        if (words_out >= total)
        begin
            voxels_in = 0;
            words_out = 0;
        end
    endtask

    task automatic compare_word(input result_word_t got);
        result_word_t want;
        if (eroded_due.size() == 0)
        begin
            note_mismatch($sformatf("result word with none expected: label %h last %b",
                got.out_label, got.last_voxel));
            return;
        end
        want = eroded_due.pop_front();
        if (want.out_label !== got.out_label)
        begin
            note_mismatch($sformatf("out_label expected %h actual %h",
                want.out_label, got.out_label));
        end
        if (want.last_voxel !== got.last_voxel)
        begin
            note_mismatch($sformatf("last_voxel expected %b actual %b (label %h)",
                want.last_voxel, got.last_voxel, want.out_label));
        end
    endtask

    always @(posedge clk)
    begin
        result_word_t seen;
        if (!rst_n)
        begin
            voxels_in      = 0;
            words_out      = 0;
            x_size         = X_SIZE_RESET;
            y_size         = Y_SIZE_RESET;
            z_size         = Z_SIZE_RESET;
            mismatch_count = 0;
            eroded_due.delete();
        end
        else
        begin
            // Results leave through the pipeline registers after their release, so the
            // output side is always checked against older expectations.
            if (result.valid && result.ready)
            begin
                seen.out_label  = result.out_label;
                seen.last_voxel = result.last_voxel;
                compare_word(seen);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_X_SIZE: x_size = cfg_data[X_SIZE_W-1:0];
                    CFG_Y_SIZE: y_size = cfg_data[Y_SIZE_W-1:0];
                    CFG_Z_SIZE: z_size = cfg_data[Z_SIZE_W-1:0];
                    default: ;
                endcase
                voxels_in = 0;
                words_out = 0;
            end
            if (voxel.valid && voxel.ready)
            begin
                absorb_word(voxel.voxel_label, voxel.flush);
            end
        end
        words_due = eroded_due.size();
    end

endmodule

// File: tb/label_erosion_3d_six_neighbour_top_test.sv
// Stimulus and verdict for the six-neighbour label erosion block.
module label_erosion_3d_six_neighbour_top_test import le3d_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // The one register index beyond the list; a write to it only restarts the volume.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Cycles allowed after the last expected word before a register write, to
    // cover words still in flight that release nothing.
    localparam int SETTLE_CYCLES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    words_due;

    // Idling controls: tx_gaps is used by the stimulus process only, rx_stalls
    // by the receiver process.
    bit                    tx_gaps;
    bit                    rx_stalls;

    // Volume shape as the block will use it, after its own size clamping.
    // This only shapes the stimulus; the checker predicts on its own.
    int unsigned           plane_words;
    int unsigned           volume_words;
    int unsigned           counted_words;

    le3d_in_if  voxel_if ();
    le3d_out_if result_if ();

    label_erosion_3d_six_neighbour_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .voxel     (voxel_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    le3d_erosion_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .voxel          (voxel_if),
        .result         (result_if),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: ready drops in random bursts while rx_stalls is set and stays
    // high otherwise.  Each change is made at a rising edge.
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_stalls && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    // Hard limit on the run, far above the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("label_erosion_3d_six_neighbour_top_test failed");
        $finish;
    end

    function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    // Labels with a chosen share of background; the extremes show up often.
    function automatic logic [LABEL_W-1:0] pick_label(input int unsigned zero_odds);
        if ($urandom_range(0, 15) < zero_odds)
        begin
            return '0;
        end
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0001;
            default: return LABEL_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic int unsigned pick_dim(input int unsigned hi);
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, hi);
    endfunction

    // Offers one word and returns at the edge that accepts it.  Valid stays
    // high afterwards, so back-to-back words need no second assignment.  Ready
    // is looked at on the falling edge, where nothing is changing.
    task automatic send_word(input logic [LABEL_W-1:0] label, input logic flush);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            voxel_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        voxel_if.valid       <= 1'b1;
        voxel_if.voxel_label <= label;
        voxel_if.flush       <= flush;
        do
            @(negedge clk);
        while (!voxel_if.ready);
        @(posedge clk);
    endtask

    // Holds the sender back until every expected word has come out.
    task automatic drain_results();
        voxel_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (words_due != 0);
        @(posedge clk);
    endtask

    // Brings the block to rest before touching its registers.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the extra edge keeps the enable from being lowered
    // and raised again in one time step when writes follow each other.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all three sizes.  The row and column registers are narrower than
    // the data bus, so their upper data bits carry noise that must be dropped.
    task automatic set_sizes(input int unsigned xs, input int unsigned ys, input int unsigned zs);
        settle();
        cfg_write(CFG_X_SIZE, CFG_DATA_W'(xs));
        cfg_write(CFG_Y_SIZE, {6'($urandom_range(0, 63)), Y_SIZE_W'(ys)});
        cfg_write(CFG_Z_SIZE, {6'($urandom_range(0, 63)), Z_SIZE_W'(zs)});
        plane_words  = clip_size(ys % 128, DEF_MAX_ROWS) * clip_size(zs % 128, DEF_MAX_COLS);
        volume_words = clip_size(xs % 8192, X_LIMIT) * plane_words;
    endtask

    // One volume.  A complete one sends every voxel and then one plane of
    // flush words to drain it.  A noisy one also mixes in flush words before
    // the volume is in and stray voxels while it drains; the block ignores
    // both.  An incomplete one stops part way and is abandoned by a write.
    task automatic run_volume(input int unsigned zero_odds, input bit noisy, input bit complete);
        int unsigned stop;
        stop = complete ? volume_words : $urandom_range(0, volume_words - 1);
        for (int unsigned i = 0; i < stop; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
            begin
                send_word(pick_label(0), 1'b1);
            end
            if ($urandom_range(0, 299) == 0)
            begin
                drain_results();
            end
            send_word(pick_label(zero_odds), 1'b0);
            counted_words++;
        end
        if (!complete)
        begin
            settle();
            cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
            return;
        end
        for (int unsigned j = 0; j < plane_words; j++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
            begin
                send_word(pick_label(zero_odds), 1'b0);
            end
            send_word(pick_label(0), 1'b1);
            counted_words++;
        end
    endtask

    initial
    begin
        // Every input is known from time zero, while reset is held low.
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_X_SIZE;
        cfg_data             <= '0;
        voxel_if.valid       <= 1'b0;
        voxel_if.voxel_label <= '0;
        voxel_if.flush       <= 1'b0;
        tx_gaps               = 1'b1;
        rx_stalls            <= 1'b1;
        counted_words         = 0;
        plane_words           = 64 * 64;
        volume_words          = 64 * 64 * 64;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.  A flush before any voxel releases nothing.
        send_word(16'hA5A5, 1'b1);

        // A few voxels at the reset sizes, then a write to the spare index,
        // which abandons the volume but leaves the sizes alone.
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        settle();
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));

        // A single voxel volume: it comes out only when flushed.
        set_sizes(1, 1, 1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b1);

        // Zero sizes act as one.
        set_sizes(0, 0, 0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);

        // Two planes of two voxels.  A voxel after the volume is in is dropped,
        // and a flush after the last result starts no new output.
        set_sizes(2, 1, 2);
        send_word(16'h0005, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0007, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h1234, 1'b0);
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b1);

        // A volume with one background voxel and a full drain in the middle.
        set_sizes(2, 2, 1);
        send_word(16'h0009, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b0);
        drain_results();
        send_word(16'h0002, 1'b0);
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b1);

        // Random part: small volumes of random shape.  Some keep the sizes and
        // so follow the previous volume without a gap; a few are abandoned.
        counted_words = 0;
        while (counted_words < 150)
        begin
            tx_gaps    = ($urandom_range(0, 3) != 0);
            rx_stalls <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7)
            begin
                set_sizes(pick_dim(6), pick_dim(4), pick_dim(4));
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                settle();
                cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
            end
            run_volume($urandom_range(0, 8), $urandom_range(0, 2) == 0,
                       $urandom_range(0, 9) >= 2);
        end

        // Last part, with no idling on either side: shapes whose row count
        // and column count are each held to their limit.
        tx_gaps    = 1'b0;
        rx_stalls <= 1'b0;
        set_sizes(1, 127, 1);
        run_volume(2, 1'b0, 1'b1);
        set_sizes(2, 1, 127);
        run_volume(3, 1'b1, 1'b1);

        // Wait for the last words, with a bound, then a few more cycles to
        // catch anything extra.
        voxel_if.valid <= 1'b0;
        for (int i = 0; i < 50000 && words_due != 0; i++)
        begin
            @(negedge clk);
        end
        repeat (16) @(posedge clk);

        if (mismatch_count == 0 && words_due == 0)
        begin
            $display("label_erosion_3d_six_neighbour_top_test passed");
        end
        else
        begin
            $display("label_erosion_3d_six_neighbour_top_test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/le3d_pkg.sv
design/le3d_in_if.sv
design/le3d_out_if.sv
design/le3d_ram.sv
design/le3d_ctrl.sv
design/label_erosion_3d_six_neighbour_top.sv
tb/le3d_erosion_checker.sv
tb/label_erosion_3d_six_neighbour_top_test.sv
